FILE: hw/rtl/amsp_pkg.sv
// Shared types and constants for the application metadata section parser.
`timescale 1ns / 1ps

package amsp_pkg;

	// Container layout
	localparam logic [3:0]  HEADER_LAST       = 4'd13;
	localparam logic [3:0]  LEN_FIRST_POS     = 4'd6;
	localparam logic [3:0]  LEN_LAST_POS      = 4'd9;
	localparam logic [31:0] SECTION_HEAD_BYTES = 32'd5;
	localparam logic [31:0] LEN_BYTES         = 32'd4;
	localparam logic [1:0]  LAST_FIELD        = 2'd2;
	localparam logic [1:0]  WORD_LAST_BYTE    = 2'd3;
	localparam logic [7:0]  TAG_AT_RESET      = 8'd6;
	localparam logic [4:0]  KEPT_MAX          = 5'd31;

	// Result kinds
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_FIELD  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Final status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_META    = 2'd1;
	localparam logic [1:0] ST_SECT_OVER  = 2'd2;
	localparam logic [1:0] ST_FIELD_OVER = 2'd3;

	// Result queue geometry
	localparam int unsigned RES_DEPTH = 8;
	localparam int unsigned RES_PW    = 3;
	localparam int unsigned RES_CW    = 4;
	localparam int unsigned RES_SLOTS = 3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SECT_TAG,
		PH_SECT_LEN,
		PH_SKIP,
		PH_FIELD_LEN,
		PH_FIELD_DATA,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] field_index;
		logic [7:0] char_value;
		logic [4:0] kept_length;
		logic [1:0] status;
		logic       last;
	} result_t;

	// Up to three results caused by one byte, in output order
	typedef struct packed {
		logic [RES_SLOTS-1:0]   valid;
		result_t [RES_SLOTS-1:0] slot;
	} push_t;

endpackage

FILE: hw/rtl/amsp_parser_core.sv
// Parser state and per-byte result generation.
`timescale 1ns / 1ps

module amsp_parser_core #(
	parameter int NAME_CAPACITY = 32,
	parameter int ICON_CAPACITY = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       data_byte,
	input  logic             start_of_file,
	input  logic [7:0]       metadata_tag,
	output amsp_pkg::push_t  push
);
	import amsp_pkg::*;

	localparam int MAX_CAP = (NAME_CAPACITY > ICON_CAPACITY) ? NAME_CAPACITY : ICON_CAPACITY;
	localparam int KW = $clog2(MAX_CAP);
	localparam int SW = (KW > 5) ? KW : 5;
	localparam logic [KW-1:0] NAME_LIMIT = KW'(NAME_CAPACITY - 1);
	localparam logic [KW-1:0] ICON_LIMIT = KW'(ICON_CAPACITY - 1);

	phase_t        phase_q;
	logic [3:0]    header_pos_q;
	logic [31:0]   payload_rem_q;
	logic [31:0]   word_q;
	logic [1:0]    word_cnt_q;
	logic [7:0]    tag_q;
	logic [31:0]   section_rem_q;
	logic [1:0]    field_q;
	logic [31:0]   field_rem_q;
	logic [KW-1:0] kept_q;

	phase_t        phase_n;
	logic [3:0]    header_pos_n;
	logic [31:0]   payload_rem_n;
	logic [31:0]   word_n;
	logic [1:0]    word_cnt_n;
	logic [7:0]    tag_n;
	logic [31:0]   section_rem_n;
	logic [1:0]    field_n;
	logic [31:0]   field_rem_n;
	logic [KW-1:0] kept_n;

	// Saturate the kept count to the 5-bit result field
	function automatic logic [4:0] sat_kept(input logic [KW-1:0] k);
		logic [SW-1:0] kx;
		kx = SW'(k);
		return (kx > SW'(KEPT_MAX)) ? KEPT_MAX : kx[4:0];
	endfunction

	// Next state and results for the byte in the input register
	always_comb begin
		phase_t        ph;
		logic [31:0]   full;
		logic [31:0]   pay_dec;
		logic [1:0]    hp_off;
		logic [KW-1:0] limit;
		logic          do_end;
		logic          do_begin;
		logic          do_boundary;
		logic          fin;
		logic [1:0]    fin_code;
		result_t       r0;
		result_t       r1;
		result_t       r2;
		logic [2:0]    v;

		// Restart drops all progress; the byte becomes header byte 0
		if (start_of_file) begin
			ph            = PH_HEADER;
			header_pos_n  = '0;
			payload_rem_n = '0;
			word_n        = '0;
			word_cnt_n    = '0;
			tag_n         = '0;
			section_rem_n = '0;
			field_n       = '0;
			field_rem_n   = '0;
			kept_n        = '0;
		end else begin
			ph            = phase_q;
			header_pos_n  = header_pos_q;
			payload_rem_n = payload_rem_q;
			word_n        = word_q;
			word_cnt_n    = word_cnt_q;
			tag_n         = tag_q;
			section_rem_n = section_rem_q;
			field_n       = field_q;
			field_rem_n   = field_rem_q;
			kept_n        = kept_q;
		end
		phase_n     = ph;
		full        = word_n | (32'(data_byte) << {word_cnt_n, 3'b000});
		pay_dec     = payload_rem_n - 32'd1;
		hp_off      = 2'(header_pos_n - LEN_FIRST_POS);
		limit       = (field_n == LAST_FIELD) ? ICON_LIMIT : NAME_LIMIT;
		do_end      = 1'b0;
		do_begin    = 1'b0;
		do_boundary = 1'b0;
		fin         = 1'b0;
		fin_code    = ST_OK;
		r0          = '0;
		r1          = '0;
		r2          = '0;
		v           = '0;

		unique case (ph)
			PH_HEADER: begin
				if (header_pos_n >= LEN_FIRST_POS && header_pos_n <= LEN_LAST_POS) begin
					word_n = word_n | (32'(data_byte) << {hp_off, 3'b000});
				end
				if (header_pos_n >= HEADER_LAST) begin
					payload_rem_n = word_n;
					word_n        = '0;
					do_boundary   = 1'b1;
				end else begin
					header_pos_n = header_pos_n + 4'd1;
				end
			end
			PH_SECT_TAG: begin
				tag_n         = data_byte;
				payload_rem_n = pay_dec;
				word_n        = '0;
				word_cnt_n    = '0;
				phase_n       = PH_SECT_LEN;
			end
			PH_SECT_LEN: begin
				word_n        = full;
				payload_rem_n = pay_dec;
				if (word_cnt_n == WORD_LAST_BYTE) begin
					section_rem_n = full;
					if (full > pay_dec) begin
						fin      = 1'b1;
						fin_code = ST_SECT_OVER;
					end else begin
						payload_rem_n = pay_dec - full;
						if (tag_n == metadata_tag) begin
							field_n  = '0;
							do_begin = 1'b1;
						end else if (full == '0) begin
							do_boundary = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end else begin
					word_cnt_n = word_cnt_n + 2'd1;
				end
			end
			PH_SKIP: begin
				section_rem_n = section_rem_n - 32'd1;
				if (section_rem_n == '0) begin
					do_boundary = 1'b1;
				end
			end
			PH_FIELD_LEN: begin
				word_n        = full;
				section_rem_n = section_rem_n - 32'd1;
				if (word_cnt_n == WORD_LAST_BYTE) begin
					field_rem_n = full;
					kept_n      = '0;
					if (full > section_rem_n) begin
						fin      = 1'b1;
						fin_code = ST_FIELD_OVER;
					end else if (full == '0) begin
						do_end = 1'b1;
					end else begin
						phase_n = PH_FIELD_DATA;
					end
				end else begin
					word_cnt_n = word_cnt_n + 2'd1;
				end
			end
			PH_FIELD_DATA: begin
				section_rem_n = section_rem_n - 32'd1;
				field_rem_n   = field_rem_n - 32'd1;
				if (kept_n < limit) begin
					v[0]          = 1'b1;
					r0.kind       = KIND_CHAR;
					r0.field_index = field_n;
					r0.char_value = data_byte;
					kept_n        = kept_n + KW'(1);
				end
				if (field_rem_n == '0) begin
					do_end = 1'b1;
				end
			end
			default: begin
				// idle or done: ignore the byte
			end
		endcase

		// Close the string: report its kept length, move to the next one
		if (do_end) begin
			v[1]           = 1'b1;
			r1.kind        = KIND_FIELD;
			r1.field_index = field_n;
			r1.kept_length = sat_kept(kept_n);
			if (field_n == LAST_FIELD) begin
				fin      = 1'b1;
				fin_code = ST_OK;
			end else begin
				do_begin = 1'b1;
			end
			field_n = field_n + 2'd1;
		end

		// Start a string length, if the section still holds one
		if (do_begin) begin
			if (section_rem_n < LEN_BYTES) begin
				fin      = 1'b1;
				fin_code = ST_FIELD_OVER;
			end else begin
				phase_n    = PH_FIELD_LEN;
				word_n     = '0;
				word_cnt_n = '0;
			end
		end

		// Section boundary: stop when no full section head is left
		if (do_boundary) begin
			if (payload_rem_n < SECTION_HEAD_BYTES) begin
				fin      = 1'b1;
				fin_code = ST_NO_META;
			end else begin
				phase_n = PH_SECT_TAG;
			end
		end

		if (fin) begin
			v[2]      = 1'b1;
			r2.kind   = KIND_STATUS;
			r2.status = fin_code;
			phase_n   = PH_DONE;
		end

		// Mark the last result of this byte
		r0.last = v[0] & ~v[1] & ~v[2];
		r1.last = v[1] & ~v[2];
		r2.last = v[2];

		push.valid   = fire ? v : 3'b000;
		push.slot[0] = r0;
		push.slot[1] = r1;
		push.slot[2] = r2;
	end

	// Advance parser state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			header_pos_q  <= '0;
			payload_rem_q <= '0;
			word_q        <= '0;
			word_cnt_q    <= '0;
			tag_q         <= '0;
			section_rem_q <= '0;
			field_q       <= '0;
			field_rem_q   <= '0;
			kept_q        <= '0;
		end else if (fire) begin
			phase_q       <= phase_n;
			header_pos_q  <= header_pos_n;
			payload_rem_q <= payload_rem_n;
			word_q        <= word_n;
			word_cnt_q    <= word_cnt_n;
			tag_q         <= tag_n;
			section_rem_q <= section_rem_n;
			field_q       <= field_n;
			field_rem_q   <= field_rem_n;
			kept_q        <= kept_n;
		end
	end

endmodule

FILE: hw/rtl/amsp_result_fifo.sv
// Result queue: takes up to three results per cycle, hands out one.
`timescale 1ns / 1ps

module amsp_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  amsp_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output amsp_pkg::result_t head
);
	import amsp_pkg::*;

	result_t             entry_q [RES_DEPTH];
	logic [RES_PW-1:0]   wr_ptr_q;
	logic [RES_PW-1:0]   rd_ptr_q;
	logic [RES_CW-1:0]   count_q;
	logic                pop;
	logic [RES_PW-1:0]   off1;
	logic [RES_PW-1:0]   off2;
	logic [RES_CW-1:0]   npush;

	// Compact the valid results into consecutive entries
	assign off1  = RES_PW'(push.valid[0]);
	assign off2  = RES_PW'(push.valid[0]) + RES_PW'(push.valid[1]);
	assign npush = RES_CW'(push.valid[0]) + RES_CW'(push.valid[1]) + RES_CW'(push.valid[2]);

	assign pop       = out_valid && !out_stall;
	assign out_valid = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign room      = (count_q <= RES_CW'(RES_DEPTH - RES_SLOTS));

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.valid[0]) begin
			entry_q[wr_ptr_q] <= push.slot[0];
		end
		if (push.valid[1]) begin
			entry_q[wr_ptr_q + off1] <= push.slot[1];
		end
		if (push.valid[2]) begin
			entry_q[wr_ptr_q + off2] <= push.slot[2];
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PW'(npush);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PW'(1);
			end
			count_q <= count_q + npush - RES_CW'(pop);
		end
	end

endmodule

FILE: hw/rtl/app_metadata_section_parser_unit.sv
// Top level of the application metadata section parser.
// A byte is registered in the input register, its results in the result queue.
// Throughput: one byte per cycle while the eight-entry queue has room for three
// results; a byte can cause up to three results, drained one per cycle unless stalled.
// Reset: asynchronous, active low; parser idle until start_of_file, tag resets to 6.
`timescale 1ns / 1ps

module app_metadata_section_parser_unit #(
	parameter int NAME_CAPACITY = 32,
	parameter int ICON_CAPACITY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       start_of_file,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [1:0] field_index,
	output logic [7:0] char_value,
	output logic [4:0] kept_length,
	output logic [1:0] status,
	output logic       last
);
	import amsp_pkg::*;

	logic [7:0] tag_q;
	logic       in_valid_s1;
	logic [7:0] data_byte_s1;
	logic       start_of_file_s1;
	logic       room;
	logic       fire;
	push_t      push;
	result_t    head;

	// Hold the item in the input register while the queue is short of room
	assign fire     = in_valid_s1 && room;
	assign in_stall = in_valid_s1 && !room;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= TAG_AT_RESET;
		end else if (cfg_write_en) begin
			tag_q <= cfg_write_data;
		end
	end

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_byte_s1     <= data_byte;
			start_of_file_s1 <= start_of_file;
		end
	end

	amsp_parser_core #(
		.NAME_CAPACITY(NAME_CAPACITY),
		.ICON_CAPACITY(ICON_CAPACITY)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.data_byte    (data_byte_s1),
		.start_of_file(start_of_file_s1),
		.metadata_tag (tag_q),
		.push         (push)
	);

	amsp_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	// Drive result fields from the queue head
	assign kind        = head.kind;
	assign field_index = head.field_index;
	assign char_value  = head.char_value;
	assign kept_length = head.kept_length;
	assign status      = head.status;
	assign last        = head.last;

endmodule
